>>> src/m3inv_pkg.sv
// Shared widths, types and helpers for the 3x3 matrix inverse block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package m3inv_pkg;

  localparam int ENT_W     = 16;               // Q8.8 matrix entry
  localparam int NUM_ENT   = 9;
  localparam int COF_W     = 33;               // exact cofactor, Q16.16
  localparam int PD_W      = COF_W + ENT_W;    // entry times cofactor
  localparam int DET_W     = PD_W + 2;         // sum of three partials, Q24.24
  localparam int MAG_W     = DET_W - 1;        // |det|
  localparam int SCL_W     = ENT_W;            // largest |entry|
  localparam int S2_W      = 2 * SCL_W;
  localparam int S3_W      = 3 * SCL_W;
  localparam int TOL_W     = 32;
  localparam int TH_W      = TOL_W / 2;
  localparam int XP_W      = TH_W + S3_W;      // half tolerance times scale cubed
  localparam int PP_W      = TOL_W + S3_W;     // full tolerance product
  localparam int BND_W     = PP_W - TOL_W;
  localparam int Q_W       = 32;               // Q16.16 result
  localparam int FRAC_SH   = 24;               // adj * 2^24 / det
  localparam int NUM_W     = COF_W - 1 + FRAC_SH;
  localparam int CMP_W     = MAG_W + Q_W + 1;  // width of divisor compares
  localparam int DIV_STEPS = Q_W;

  localparam logic [Q_W-1:0] Q_POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_NEG_MAX = {1'b1, {(Q_W-1){1'b0}}};

  typedef logic signed [ENT_W-1:0] ent_t;
  typedef logic signed [COF_W-1:0] cof_t;
  typedef logic signed [Q_W-1:0]   res_t;

  // Determinant data handed from the front end to every lane
  typedef struct packed {
    logic             det_neg;
    logic [MAG_W-1:0] det_mag;
  } det_info_t;

  // Signed 16x16 product, widened to cofactor width
  function automatic cof_t prod16(input ent_t x, input ent_t y);
    cof_t px, py;
    px = COF_W'(x);
    py = COF_W'(y);
    return px * py;
  endfunction

endpackage
`default_nettype wire

>>> src/m3inv_front.sv
// Front end: cofactors, determinant, scale and the singularity test.
// Six register stages; uses m3inv_pkg.
`default_nettype none
module m3inv_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         take,
  input  wire m3inv_pkg::ent_t              m [m3inv_pkg::NUM_ENT],
  input  wire logic [m3inv_pkg::TOL_W-1:0]  tol,
  output logic                              v,
  output logic                              sing,
  output m3inv_pkg::det_info_t              dinfo,
  output m3inv_pkg::cof_t                   cof [m3inv_pkg::NUM_ENT]
);

  logic v1, v2, v3, v4, v5, v6;

  m3inv_pkg::cof_t cof1 [m3inv_pkg::NUM_ENT];
  m3inv_pkg::cof_t cof2 [m3inv_pkg::NUM_ENT];
  m3inv_pkg::cof_t cof3 [m3inv_pkg::NUM_ENT];
  m3inv_pkg::cof_t cof4 [m3inv_pkg::NUM_ENT];
  m3inv_pkg::cof_t cof5 [m3inv_pkg::NUM_ENT];
  m3inv_pkg::cof_t cof6 [m3inv_pkg::NUM_ENT];

  m3inv_pkg::ent_t                   row1 [3];
  logic [m3inv_pkg::SCL_W-1:0]       abs1 [m3inv_pkg::NUM_ENT];
  logic signed [m3inv_pkg::PD_W-1:0] pd2  [3];
  logic [m3inv_pkg::SCL_W-1:0]       scale2, scale3;
  logic signed [m3inv_pkg::DET_W-1:0] det3;
  logic [m3inv_pkg::S2_W-1:0]        s2_3;
  m3inv_pkg::det_info_t              d4, d5, d6;
  logic [m3inv_pkg::S3_W-1:0]        s3_4;
  logic                              zero4, zero5;
  logic [m3inv_pkg::XP_W-1:0]        x5, y5;
  logic                              sing6;

  logic [m3inv_pkg::SCL_W-1:0]       scale_max;
  logic [m3inv_pkg::PP_W-1:0]        pprod;
  logic [m3inv_pkg::BND_W-1:0]       bound;
  logic [m3inv_pkg::MAG_W-1:0]       det_abs;

  // Largest absolute entry
  always_comb begin
    scale_max = '0;
    for (int k = 0; k < m3inv_pkg::NUM_ENT; k++) begin
      if (abs1[k] > scale_max) begin
        scale_max = abs1[k];
      end
    end
  end

  assign det_abs = det3[m3inv_pkg::DET_W-1] ? m3inv_pkg::MAG_W'(-det3)
                                            : m3inv_pkg::MAG_W'(det3);

  // floor(tol * s^3 / 2^32) from the two half products
  assign pprod = {x5, {m3inv_pkg::TH_W{1'b0}}} + m3inv_pkg::PP_W'(y5);
  assign bound = pprod[m3inv_pkg::PP_W-1:m3inv_pkg::TOL_W];

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else if (en) begin
      v1 <= take; v2 <= v1; v3 <= v2;
      v4 <= v3;   v5 <= v4; v6 <= v5;
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // cofactors and absolute entries
      cof1[0] <= m3inv_pkg::prod16(m[4], m[8]) - m3inv_pkg::prod16(m[5], m[7]);
      cof1[1] <= m3inv_pkg::prod16(m[2], m[7]) - m3inv_pkg::prod16(m[1], m[8]);
      cof1[2] <= m3inv_pkg::prod16(m[1], m[5]) - m3inv_pkg::prod16(m[2], m[4]);
      cof1[3] <= m3inv_pkg::prod16(m[5], m[6]) - m3inv_pkg::prod16(m[3], m[8]);
      cof1[4] <= m3inv_pkg::prod16(m[0], m[8]) - m3inv_pkg::prod16(m[2], m[6]);
      cof1[5] <= m3inv_pkg::prod16(m[2], m[3]) - m3inv_pkg::prod16(m[0], m[5]);
      cof1[6] <= m3inv_pkg::prod16(m[3], m[7]) - m3inv_pkg::prod16(m[4], m[6]);
      cof1[7] <= m3inv_pkg::prod16(m[1], m[6]) - m3inv_pkg::prod16(m[0], m[7]);
      cof1[8] <= m3inv_pkg::prod16(m[0], m[4]) - m3inv_pkg::prod16(m[1], m[3]);
      for (int k = 0; k < 3; k++) begin
        row1[k] <= m[k];
      end
      for (int k = 0; k < m3inv_pkg::NUM_ENT; k++) begin
        abs1[k] <= m[k][m3inv_pkg::ENT_W-1] ? m3inv_pkg::SCL_W'(~m[k] + 1'b1)
                                            : m3inv_pkg::SCL_W'(m[k]);
      end
      // determinant partials along row 0, scale
      for (int k = 0; k < 3; k++) begin
        pd2[k] <= m3inv_pkg::PD_W'(row1[k]) * m3inv_pkg::PD_W'(cof1[3 * k]);
      end
      scale2 <= scale_max;
      // determinant, scale squared
      det3   <= m3inv_pkg::DET_W'(pd2[0]) + m3inv_pkg::DET_W'(pd2[1])
              + m3inv_pkg::DET_W'(pd2[2]);
      s2_3   <= m3inv_pkg::S2_W'(scale2) * m3inv_pkg::S2_W'(scale2);
      scale3 <= scale2;
      // |det|, scale cubed
      d4.det_neg <= det3[m3inv_pkg::DET_W-1];
      d4.det_mag <= det_abs;
      s3_4       <= m3inv_pkg::S3_W'(s2_3) * m3inv_pkg::S3_W'(scale3);
      zero4      <= (scale3 == '0);
      // tolerance times scale cubed, in two halves
      d5    <= d4;
      zero5 <= zero4;
      x5    <= m3inv_pkg::XP_W'(tol[m3inv_pkg::TOL_W-1:m3inv_pkg::TH_W])
             * m3inv_pkg::XP_W'(s3_4);
      y5    <= m3inv_pkg::XP_W'(tol[m3inv_pkg::TH_W-1:0]) * m3inv_pkg::XP_W'(s3_4);
      // singularity decision
      d6    <= d5;
      sing6 <= zero5 || (d5.det_mag <= m3inv_pkg::MAG_W'(bound));
      cof2 <= cof1; cof3 <= cof2; cof4 <= cof3;
      cof5 <= cof4; cof6 <= cof5;
    end
  end

  assign v     = v6;
  assign sing  = sing6;
  assign dinfo = d6;
  assign cof   = cof6;

endmodule
`default_nettype wire

>>> src/m3inv_lane.sv
// One division lane: rounded |adj| * 2^24 / |det|, one quotient bit per stage,
// then sign and saturation. Uses m3inv_pkg.
`default_nettype none
module m3inv_lane (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire m3inv_pkg::cof_t cof,
  input  wire m3inv_pkg::det_info_t dinfo,
  output m3inv_pkg::res_t     res
);

  localparam int NSTG = m3inv_pkg::DIV_STEPS;

  logic [m3inv_pkg::NUM_W-1:0] rem_r [NSTG+1];
  logic [m3inv_pkg::MAG_W-1:0] den_r [NSTG+1];
  logic [m3inv_pkg::Q_W-1:0]   quo_r [NSTG+1];
  logic                        ovf_r [NSTG+1];
  logic                        neg_r [NSTG+1];

  logic [m3inv_pkg::COF_W-2:0] cof_abs;
  logic [m3inv_pkg::NUM_W-1:0] num;
  logic [m3inv_pkg::Q_W-1:0]   qf;
  logic                        sat_pos, sat_neg;

  assign cof_abs = cof[m3inv_pkg::COF_W-1] ? (m3inv_pkg::COF_W-1)'(-cof)
                                           : (m3inv_pkg::COF_W-1)'(cof);
  // numerator with half the divisor added for round to nearest
  assign num = {cof_abs, {m3inv_pkg::FRAC_SH{1'b0}}}
             + m3inv_pkg::NUM_W'(dinfo.det_mag >> 1);

  // Entry stage: numerator and overflow past 32 quotient bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= dinfo.det_mag;
      quo_r[0] <= '0;
      neg_r[0] <= cof[m3inv_pkg::COF_W-1] ^ dinfo.det_neg;
      ovf_r[0] <= m3inv_pkg::CMP_W'(num)
               >= (m3inv_pkg::CMP_W'(dinfo.det_mag) << m3inv_pkg::Q_W);
    end
  end

  // Restoring steps, most significant quotient bit first
  for (genvar j = 1; j <= NSTG; j++) begin : g_step
    localparam int BIT = NSTG - j;
    logic [m3inv_pkg::CMP_W-1:0] trial;
    logic                        hit;
    assign trial = m3inv_pkg::CMP_W'(den_r[j-1]) << BIT;
    assign hit   = m3inv_pkg::CMP_W'(rem_r[j-1]) >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= hit ? m3inv_pkg::NUM_W'(m3inv_pkg::CMP_W'(rem_r[j-1]) - trial)
                        : rem_r[j-1];
        quo_r[j] <= quo_r[j-1] | (m3inv_pkg::Q_W'(hit) << BIT);
        den_r[j] <= den_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
        neg_r[j] <= neg_r[j-1];
      end
    end
  end

  // Sign and saturate
  assign qf      = quo_r[NSTG];
  assign sat_pos = ovf_r[NSTG] || qf[m3inv_pkg::Q_W-1];
  assign sat_neg = ovf_r[NSTG] || (qf[m3inv_pkg::Q_W-1] && (qf[m3inv_pkg::Q_W-2:0] != '0));

  always_comb begin
    if (neg_r[NSTG]) begin
      res = sat_neg ? m3inv_pkg::Q_NEG_MAX : -qf;
    end else begin
      res = sat_pos ? m3inv_pkg::Q_POS_MAX : qf;
    end
  end

endmodule
`default_nettype wire

>>> src/mat3_inverse_singular_check.sv
// Top level: front end, nine division lanes, result merge and output skid.
// Uses m3inv_pkg, m3inv_front and m3inv_lane.
//
//   channel   signals                      payload
//   item      item_valid / item_stall      m00 .. m22 (signed Q8.8)
//   result    result_valid / result_stall  inv00 .. inv22 (signed Q16.16), singular
//   config    wr_en                        wr_data (singularity tolerance, Q0.32)
//
// One matrix is taken every cycle while item_stall is low; the path holds 6 front-end
// stages, 33 bit-per-stage divider stages and 1 output register.
// Synchronous reset empties the pipeline and sets the tolerance to zero.
// While the result side stalls, one more result is parked in a skid register;
// once that is full, item_stall rises and the whole pipeline holds.
`default_nettype none
module mat3_inverse_singular_check (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [31:0] wr_data,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic signed [15:0] m00,
  input  wire logic signed [15:0] m01,
  input  wire logic signed [15:0] m02,
  input  wire logic signed [15:0] m10,
  input  wire logic signed [15:0] m11,
  input  wire logic signed [15:0] m12,
  input  wire logic signed [15:0] m20,
  input  wire logic signed [15:0] m21,
  input  wire logic signed [15:0] m22,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic signed [31:0] inv00,
  output logic signed [31:0] inv01,
  output logic signed [31:0] inv02,
  output logic signed [31:0] inv10,
  output logic signed [31:0] inv11,
  output logic signed [31:0] inv12,
  output logic signed [31:0] inv20,
  output logic signed [31:0] inv21,
  output logic signed [31:0] inv22,
  output logic             singular
);

  localparam int NSTG = m3inv_pkg::DIV_STEPS;

  logic [m3inv_pkg::TOL_W-1:0] tol;
  logic                        en, take;
  logic                        skid_full;

  m3inv_pkg::ent_t      mat [m3inv_pkg::NUM_ENT];
  m3inv_pkg::cof_t      cof [m3inv_pkg::NUM_ENT];
  m3inv_pkg::res_t      lane_res [m3inv_pkg::NUM_ENT];
  m3inv_pkg::res_t      merged   [m3inv_pkg::NUM_ENT];
  m3inv_pkg::res_t      out_r    [m3inv_pkg::NUM_ENT];
  m3inv_pkg::res_t      skid_r   [m3inv_pkg::NUM_ENT];
  m3inv_pkg::det_info_t dinfo;
  logic                 fv, fsing;
  logic                 vq [NSTG+1];
  logic                 sq [NSTG+1];
  logic                 out_sing, skid_sing;
  logic                 out_free, tail_take;

  assign mat[0] = m00; assign mat[1] = m01; assign mat[2] = m02;
  assign mat[3] = m10; assign mat[4] = m11; assign mat[5] = m12;
  assign mat[6] = m20; assign mat[7] = m21; assign mat[8] = m22;

  // Pipeline moves whenever the skid register is free
  assign en         = !skid_full;
  assign item_stall = skid_full;
  assign take       = item_valid && !skid_full;

  // Tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (wr_en) begin
      tol <= wr_data;
    end
  end

  m3inv_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .take  (take),
    .m     (mat),
    .tol   (tol),
    .v     (fv),
    .sing  (fsing),
    .dinfo (dinfo),
    .cof   (cof)
  );

  for (genvar k = 0; k < m3inv_pkg::NUM_ENT; k++) begin : g_lane
    m3inv_lane u_lane (
      .clk   (clk),
      .en    (en),
      .cof   (cof[k]),
      .dinfo (dinfo),
      .res   (lane_res[k])
    );
  end

  // Valid and singular flags alongside the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= NSTG; j++) begin
        vq[j] <= 1'b0;
      end
    end else if (en) begin
      vq[0] <= fv;
      for (int j = 1; j <= NSTG; j++) begin
        vq[j] <= vq[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0] <= fsing;
      for (int j = 1; j <= NSTG; j++) begin
        sq[j] <= sq[j-1];
      end
    end
  end

  // Merge the lanes: zeros when singular
  always_comb begin
    for (int k = 0; k < m3inv_pkg::NUM_ENT; k++) begin
      merged[k] = sq[NSTG] ? '0 : lane_res[k];
    end
  end

  assign out_free  = !result_valid || !result_stall;
  assign tail_take = en && vq[NSTG];

  // Output register and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else if (skid_full) begin
      if (out_free) begin
        result_valid <= 1'b1;
        skid_full    <= 1'b0;
      end
    end else if (tail_take) begin
      if (out_free) begin
        result_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (out_free) begin
      result_valid <= 1'b0;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_free) begin
        out_r    <= skid_r;
        out_sing <= skid_sing;
      end
    end else if (tail_take) begin
      if (out_free) begin
        out_r    <= merged;
        out_sing <= sq[NSTG];
      end else begin
        skid_r    <= merged;
        skid_sing <= sq[NSTG];
      end
    end
  end

  assign inv00 = out_r[0]; assign inv01 = out_r[1]; assign inv02 = out_r[2];
  assign inv10 = out_r[3]; assign inv11 = out_r[4]; assign inv12 = out_r[5];
  assign inv20 = out_r[6]; assign inv21 = out_r[7]; assign inv22 = out_r[8];
  assign singular = out_sing;

  // Skid fills only behind a stalled, occupied output
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(result_valid && result_stall))
    else $error("skid filled while output was free");

  // A singular result carries zero entries; checked on inv00, inv11, inv22, inv01, inv20
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && singular |-> inv00 == 0 && inv11 == 0 && inv22 == 0
                                 && inv01 == 0 && inv20 == 0)
    else $error("singular result with nonzero entries");

  // The divider tail holds while the skid register is occupied
  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    skid_full |=> $stable(vq[NSTG]))
    else $error("pipeline moved with skid full");

endmodule
`default_nettype wire
